>>> rtl/sbt_pkg.sv
`timescale 1ns / 1ps
package sbt_pkg;

	localparam int MAX_SOURCE_BYTES_DEF = 1048576;
	localparam int KEYWORD_MAX_CHARS_DEF = 10;
	localparam int MAX_RES = 4;
	localparam logic [15:0] START_LINE_RST = 16'd1;

	localparam logic [5:0] K_IDENT = 6'd0;
	localparam logic [5:0] K_NUMBER = 6'd1;
	localparam logic [5:0] K_STRING = 6'd2;
	localparam logic [5:0] K_UNKNOWN = 6'd3;
	localparam logic [5:0] K_KW_BASE = 6'd4;
	localparam logic [5:0] K_LPAREN = 6'd13;
	localparam logic [5:0] K_RPAREN = 6'd14;
	localparam logic [5:0] K_LBRACE = 6'd15;
	localparam logic [5:0] K_RBRACE = 6'd16;
	localparam logic [5:0] K_PLUS = 6'd17;
	localparam logic [5:0] K_MINUS = 6'd18;
	localparam logic [5:0] K_STAR = 6'd19;
	localparam logic [5:0] K_SLASH = 6'd20;
	localparam logic [5:0] K_SEMI = 6'd21;
	localparam logic [5:0] K_COMMA = 6'd22;
	localparam logic [5:0] K_BANGBANG = 6'd23;
	localparam logic [5:0] K_NE = 6'd24;
	localparam logic [5:0] K_ASSIGN = 6'd25;
	localparam logic [5:0] K_EQ = 6'd26;
	localparam logic [5:0] K_LT = 6'd27;
	localparam logic [5:0] K_LE = 6'd28;
	localparam logic [5:0] K_GT = 6'd29;
	localparam logic [5:0] K_GE = 6'd30;
	localparam logic [5:0] K_END = 6'd33;
	localparam logic [5:0] K_ERROR = 6'd34;

	localparam logic [1:0] E_NONE = 2'd0;
	localparam logic [1:0] E_UNEXPECTED = 2'd1;
	localparam logic [1:0] E_UNTERM = 2'd2;

	localparam int NUM_KW = 9;
	// keyword text, first char in the low byte, zero padded to ten chars
	localparam logic [79:0] KW_TEXT [NUM_KW] = '{
		80'h6e69616d,
		80'h616973,
		80'h61706d617473,
		80'h6573,
		80'h69746e656d6972746c61,
		80'h6e7566,
		80'h646e61,
		80'h726f,
		80'h746f6e
	};
	localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd4, 4'd3, 4'd6, 4'd2, 4'd10,
		4'd3, 4'd3, 4'd2, 4'd3};

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_NUM, M_NUM_DOT, M_NUM_FRAC, M_STR, M_SLASH,
		M_LINEC, M_BLOCKC, M_BLOCKSTAR, M_BANG, M_EQ, M_LT, M_GT
	} mode_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       has_byte;
		logic       is_last;
	} in_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [1:0]  error_code;
		logic [19:0] lexeme_start;
		logic [19:0] lexeme_length;
		logic [15:0] line_number;
		logic        last_of_run;
	} out_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic [19:0] sub_sat(input logic [19:0] a, input logic [19:0] b);
		return (a > b) ? a - b : 20'd0;
	endfunction

	function automatic out_t mk(input logic [5:0] k, input logic [1:0] e,
		input logic [19:0] s, input logic [19:0] l, input logic [15:0] ln);
		out_t r;
		r.token_kind = k;
		r.error_code = e;
		r.lexeme_start = s;
		r.lexeme_length = l;
		r.line_number = ln;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	function automatic logic [5:0] word_kind(input logic [79:0] pf, input logic [4:0] wl);
		logic [5:0] k;
		k = K_IDENT;
		for (int i = NUM_KW - 1; i >= 0; i--) begin
			if (wl == {1'b0, KW_LEN[i]} && pf == KW_TEXT[i])
				k = K_KW_BASE + 6'(i);
		end
		return k;
	endfunction

endpackage

>>> rtl/source_byte_tokenizer.sv
`timescale 1ns / 1ps
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready  | in_data   (sbt_pkg::in_t)
// out     | out | out_valid / out_ready| out_data  (sbt_pkg::out_t)
// cfg     | in  | cfg_we               | cfg_wdata (start_line)
//
// one input beat per cycle when each byte yields at most one token and out_ready
// is high; a byte that yields n tokens holds the next beat in the input register
// until its n results have drained from the four-entry result buffer. an accepted
// beat waits in the input register; its results are registered when it is taken.
// arst_n clears mode, offsets, start_line (to 1) and empties the input and result buffers.
// out_ready low holds the result buffer; the next beat then waits and in_ready drops.
module source_byte_tokenizer #(
	parameter int MAX_SOURCE_BYTES = sbt_pkg::MAX_SOURCE_BYTES_DEF,
	parameter int KEYWORD_MAX_CHARS = sbt_pkg::KEYWORD_MAX_CHARS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sbt_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output sbt_pkg::out_t  out_data,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_wdata
);

	localparam int POS_MAX_I = (MAX_SOURCE_BYTES - 1 < 1048575) ? MAX_SOURCE_BYTES - 1
		: 1048575;
	localparam logic [19:0] POS_MAX = 20'(POS_MAX_I);
	localparam int PFW = 8 * KEYWORD_MAX_CHARS;
	localparam int WLW = $clog2(KEYWORD_MAX_CHARS + 2);
	localparam logic [WLW-1:0] KWMAX = WLW'(KEYWORD_MAX_CHARS);

	sbt_pkg::in_t   in_s1;
	logic           valid_s1;
	sbt_pkg::mode_t mode_q, mode_d;
	logic [19:0]    pos_q, pos_d, tstart_q, tstart_d;
	logic [15:0]    line_q, line_d, start_line_q;
	logic [PFW-1:0] pf_q, pf_d;
	logic [WLW-1:0] wl_q, wl_d;
	sbt_pkg::out_t  res_q [sbt_pkg::MAX_RES];
	sbt_pkg::out_t  res_d [sbt_pkg::MAX_RES];
	logic [2:0]     cnt_q, n_d;
	logic [1:0]     idx_q;
	logic           buf_free, take;

	assign buf_free = (cnt_q == 3'd0) || (out_ready && idx_q == 2'(cnt_q - 3'd1));
	assign take = valid_s1 && buf_free;
	assign in_ready = !valid_s1 || take;
	assign out_valid = cnt_q != 3'd0;
	assign out_data = res_q[idx_q];

	always_comb begin
		logic [7:0]  c;
		logic        used;
		logic [4:0]  wl5;
		logic [79:0] pf10;
		mode_d = mode_q;
		pos_d = pos_q;
		tstart_d = tstart_q;
		line_d = line_q;
		pf_d = pf_q;
		wl_d = wl_q;
		n_d = 3'd0;
		wl5 = '0;
		pf10 = '0;
		for (int i = 0; i < sbt_pkg::MAX_RES; i++) res_d[i] = '0;
		c = in_s1.byte_value;
		used = 1'b1;
		if (in_s1.has_byte) begin
			case (mode_d)
				sbt_pkg::M_IDENT: begin
					if (sbt_pkg::is_alpha(c) || sbt_pkg::is_digit(c)) begin
						if (wl_d < KWMAX) pf_d[8*wl_d +: 8] = c;
						if (wl_d <= KWMAX) wl_d = wl_d + 1'b1;
					end else used = 1'b0;
				end
				sbt_pkg::M_NUM: begin
					if (c == 8'h2e) mode_d = sbt_pkg::M_NUM_DOT;
					else if (!sbt_pkg::is_digit(c)) used = 1'b0;
				end
				sbt_pkg::M_NUM_DOT: begin
					if (sbt_pkg::is_digit(c)) mode_d = sbt_pkg::M_NUM_FRAC;
					else used = 1'b0;
				end
				sbt_pkg::M_NUM_FRAC: if (!sbt_pkg::is_digit(c)) used = 1'b0;
				sbt_pkg::M_STR: begin
					if (c == 8'h22) begin
						res_d[n_d[1:0]] = sbt_pkg::mk(sbt_pkg::K_STRING, sbt_pkg::E_NONE,
							tstart_d, sbt_pkg::sub_sat(pos_d, tstart_d), line_d);
						n_d = n_d + 3'd1;
						mode_d = sbt_pkg::M_IDLE;
					end else if (c == 8'h0a && line_d != 16'hffff) line_d = line_d + 16'd1;
				end
				sbt_pkg::M_SLASH: begin
					if (c == 8'h2f) mode_d = sbt_pkg::M_LINEC;
					else if (c == 8'h2a) mode_d = sbt_pkg::M_BLOCKC;
					else used = 1'b0;
				end
				sbt_pkg::M_LINEC: begin
					if (c == 8'h0a) begin
						if (line_d != 16'hffff) line_d = line_d + 16'd1;
						mode_d = sbt_pkg::M_IDLE;
					end
				end
				sbt_pkg::M_BLOCKC: begin
					if (c == 8'h2a) mode_d = sbt_pkg::M_BLOCKSTAR;
					else if (c == 8'h0a && line_d != 16'hffff) line_d = line_d + 16'd1;
				end
				sbt_pkg::M_BLOCKSTAR: begin
					if (c == 8'h2f) mode_d = sbt_pkg::M_IDLE;
					else if (c != 8'h2a) begin
						if (c == 8'h0a && line_d != 16'hffff) line_d = line_d + 16'd1;
						mode_d = sbt_pkg::M_BLOCKC;
					end
				end
				sbt_pkg::M_BANG: begin
					if (c == 8'h21 || c == 8'h3d) begin
						res_d[n_d[1:0]] = sbt_pkg::mk(c == 8'h21 ? sbt_pkg::K_BANGBANG
							: sbt_pkg::K_NE, sbt_pkg::E_NONE, tstart_d, 20'd2, line_d);
						n_d = n_d + 3'd1;
						mode_d = sbt_pkg::M_IDLE;
					end else used = 1'b0;
				end
				sbt_pkg::M_EQ, sbt_pkg::M_LT, sbt_pkg::M_GT: begin
					if (c == 8'h3d) begin
						res_d[n_d[1:0]] = sbt_pkg::mk(mode_d == sbt_pkg::M_EQ ? sbt_pkg::K_EQ
							: mode_d == sbt_pkg::M_LT ? sbt_pkg::K_LE : sbt_pkg::K_GE,
							sbt_pkg::E_NONE, tstart_d, 20'd2, line_d);
						n_d = n_d + 3'd1;
						mode_d = sbt_pkg::M_IDLE;
					end else used = 1'b0;
				end
				default: begin
					mode_d = sbt_pkg::M_IDLE;
					used = 1'b0;
				end
			endcase
			if (!used) begin
				// flush the pending token at this byte
				wl5 = 5'(wl_d);
				pf10 = pf_d[79:0];
				case (mode_d)
					sbt_pkg::M_IDENT: begin
						res_d[n_d[1:0]] = sbt_pkg::mk(sbt_pkg::word_kind(pf10, wl5),
							sbt_pkg::E_NONE, tstart_d, sbt_pkg::sub_sat(pos_d, tstart_d), line_d);
						n_d = n_d + 3'd1;
					end
					sbt_pkg::M_NUM, sbt_pkg::M_NUM_FRAC: begin
						res_d[n_d[1:0]] = sbt_pkg::mk(sbt_pkg::K_NUMBER, sbt_pkg::E_NONE,
							tstart_d, sbt_pkg::sub_sat(pos_d, tstart_d), line_d);
						n_d = n_d + 3'd1;
					end
					sbt_pkg::M_NUM_DOT: begin
						res_d[n_d[1:0]] = sbt_pkg::mk(sbt_pkg::K_NUMBER, sbt_pkg::E_NONE,
							tstart_d, sbt_pkg::sub_sat(sbt_pkg::sub_sat(pos_d, 20'd1), tstart_d),
							line_d);
						res_d[2'(n_d + 3'd1)] = sbt_pkg::mk(sbt_pkg::K_ERROR,
							sbt_pkg::E_UNEXPECTED, sbt_pkg::sub_sat(pos_d, 20'd1), 20'd1, line_d);
						n_d = n_d + 3'd2;
					end
					sbt_pkg::M_SLASH, sbt_pkg::M_BANG, sbt_pkg::M_EQ, sbt_pkg::M_LT,
					sbt_pkg::M_GT: begin
						res_d[n_d[1:0]] = sbt_pkg::mk(
							mode_d == sbt_pkg::M_SLASH ? sbt_pkg::K_SLASH :
							mode_d == sbt_pkg::M_BANG ? sbt_pkg::K_ERROR :
							mode_d == sbt_pkg::M_EQ ? sbt_pkg::K_ASSIGN :
							mode_d == sbt_pkg::M_LT ? sbt_pkg::K_LT : sbt_pkg::K_GT,
							mode_d == sbt_pkg::M_BANG ? sbt_pkg::E_UNEXPECTED : sbt_pkg::E_NONE,
							tstart_d, 20'd1, line_d);
						n_d = n_d + 3'd1;
					end
					default: ;
				endcase
				mode_d = sbt_pkg::M_IDLE;
				// start a new token with this byte
				tstart_d = pos_d;
				if (sbt_pkg::is_alpha(c) || c == 8'h5f) begin
					mode_d = sbt_pkg::M_IDENT;
					pf_d = '0;
					pf_d[7:0] = c;
					wl_d = WLW'(1);
				end else if (sbt_pkg::is_digit(c)) begin
					mode_d = sbt_pkg::M_NUM;
				end else begin
					case (c)
						8'h20, 8'h09, 8'h0d, 8'h0b, 8'h0c: ;
						8'h0a: if (line_d != 16'hffff) line_d = line_d + 16'd1;
						8'h22: begin
							mode_d = sbt_pkg::M_STR;
							tstart_d = (pos_d < POS_MAX) ? pos_d + 20'd1 : POS_MAX;
						end
						8'h2f: mode_d = sbt_pkg::M_SLASH;
						8'h21: mode_d = sbt_pkg::M_BANG;
						8'h3d: mode_d = sbt_pkg::M_EQ;
						8'h3c: mode_d = sbt_pkg::M_LT;
						8'h3e: mode_d = sbt_pkg::M_GT;
						default: begin
							res_d[n_d[1:0]] = sbt_pkg::mk(
								c == 8'h28 ? sbt_pkg::K_LPAREN :
								c == 8'h29 ? sbt_pkg::K_RPAREN :
								c == 8'h7b ? sbt_pkg::K_LBRACE :
								c == 8'h7d ? sbt_pkg::K_RBRACE :
								c == 8'h2b ? sbt_pkg::K_PLUS :
								c == 8'h2d ? sbt_pkg::K_MINUS :
								c == 8'h2a ? sbt_pkg::K_STAR :
								c == 8'h3b ? sbt_pkg::K_SEMI :
								c == 8'h2c ? sbt_pkg::K_COMMA : sbt_pkg::K_ERROR,
								(c == 8'h28 || c == 8'h29 || c == 8'h7b || c == 8'h7d ||
								c == 8'h2b || c == 8'h2d || c == 8'h2a || c == 8'h3b ||
								c == 8'h2c) ? sbt_pkg::E_NONE : sbt_pkg::E_UNEXPECTED,
								pos_d, 20'd1, line_d);
							n_d = n_d + 3'd1;
						end
					endcase
				end
			end
			pos_d = (pos_d < POS_MAX) ? pos_d + 20'd1 : POS_MAX;
		end
		if (in_s1.is_last) begin
			wl5 = 5'(wl_d);
			pf10 = pf_d[79:0];
			case (mode_d)
				sbt_pkg::M_STR: begin
					res_d[n_d[1:0]] = sbt_pkg::mk(sbt_pkg::K_UNKNOWN, sbt_pkg::E_UNTERM,
						sbt_pkg::sub_sat(tstart_d, 20'd1),
						sbt_pkg::sub_sat(pos_d, sbt_pkg::sub_sat(tstart_d, 20'd1)), line_d);
					n_d = n_d + 3'd1;
				end
				sbt_pkg::M_IDENT: begin
					res_d[n_d[1:0]] = sbt_pkg::mk(sbt_pkg::word_kind(pf10, wl5),
						sbt_pkg::E_NONE, tstart_d, sbt_pkg::sub_sat(pos_d, tstart_d), line_d);
					n_d = n_d + 3'd1;
				end
				sbt_pkg::M_NUM, sbt_pkg::M_NUM_FRAC: begin
					res_d[n_d[1:0]] = sbt_pkg::mk(sbt_pkg::K_NUMBER, sbt_pkg::E_NONE,
						tstart_d, sbt_pkg::sub_sat(pos_d, tstart_d), line_d);
					n_d = n_d + 3'd1;
				end
				sbt_pkg::M_NUM_DOT: begin
					res_d[n_d[1:0]] = sbt_pkg::mk(sbt_pkg::K_NUMBER, sbt_pkg::E_NONE,
						tstart_d, sbt_pkg::sub_sat(sbt_pkg::sub_sat(pos_d, 20'd1), tstart_d),
						line_d);
					res_d[2'(n_d + 3'd1)] = sbt_pkg::mk(sbt_pkg::K_ERROR,
						sbt_pkg::E_UNEXPECTED, sbt_pkg::sub_sat(pos_d, 20'd1), 20'd1, line_d);
					n_d = n_d + 3'd2;
				end
				sbt_pkg::M_SLASH, sbt_pkg::M_BANG, sbt_pkg::M_EQ, sbt_pkg::M_LT,
				sbt_pkg::M_GT: begin
					res_d[n_d[1:0]] = sbt_pkg::mk(
						mode_d == sbt_pkg::M_SLASH ? sbt_pkg::K_SLASH :
						mode_d == sbt_pkg::M_BANG ? sbt_pkg::K_ERROR :
						mode_d == sbt_pkg::M_EQ ? sbt_pkg::K_ASSIGN :
						mode_d == sbt_pkg::M_LT ? sbt_pkg::K_LT : sbt_pkg::K_GT,
						mode_d == sbt_pkg::M_BANG ? sbt_pkg::E_UNEXPECTED : sbt_pkg::E_NONE,
						tstart_d, 20'd1, line_d);
					n_d = n_d + 3'd1;
				end
				default: ;
			endcase
			res_d[n_d[1:0]] = sbt_pkg::mk(sbt_pkg::K_END, sbt_pkg::E_NONE, pos_d, 20'd0, line_d);
			n_d = n_d + 3'd1;
			mode_d = sbt_pkg::M_IDLE;
			pos_d = '0;
			tstart_d = '0;
			line_d = start_line_q;
			pf_d = '0;
			wl_d = '0;
		end
		if (n_d != 3'd0) res_d[2'(n_d - 3'd1)].last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q <= sbt_pkg::M_IDLE;
			pos_q <= '0;
			tstart_q <= '0;
			line_q <= sbt_pkg::START_LINE_RST;
			start_line_q <= sbt_pkg::START_LINE_RST;
			pf_q <= '0;
			wl_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (take) begin
				mode_q <= mode_d;
				pos_q <= pos_d;
				tstart_q <= tstart_d;
				line_q <= line_d;
				pf_q <= pf_d;
				wl_q <= wl_d;
				cnt_q <= n_d;
				idx_q <= '0;
			end else if (out_valid && out_ready) begin
				if (idx_q == 2'(cnt_q - 3'd1)) begin
					cnt_q <= '0;
					idx_q <= '0;
				end else idx_q <= idx_q + 2'd1;
			end
			if (cfg_we) begin
				start_line_q <= cfg_wdata;
				if (!take && pos_q == '0 && mode_q == sbt_pkg::M_IDLE) line_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) in_s1 <= in_data;
		if (take) res_q <= res_d;
	end

`ifndef SYNTHESIS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, idx_q} < cnt_q))
		else $error("result index beyond fill");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(sbt_pkg::MAX_RES))
		else $error("result count overflow");
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_of_run |-> idx_q == 2'(cnt_q - 3'd1))
		else $error("last_of_run on a non-final beat");
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_MAX && tstart_q <= POS_MAX)
		else $error("offset past saturation");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !take |=> valid_s1 && $stable(in_s1))
		else $error("input stage lost a beat");
`endif

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

	localparam int POS_LIMIT = 20'hFFFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	sbt_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	sbt_pkg::out_t out_data;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	source_byte_tokenizer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// scanner state mirrored in the testbench
	logic [15:0] first_line;
	sbt_pkg::mode_t scan_st;
	logic [19:0] cur_pos;
	logic [19:0] tok_begin;
	logic [15:0] cur_line;
	logic [7:0] word_buf [10];
	int word_len;

	sbt_pkg::in_t pending_beats[$];
	sbt_pkg::out_t token_queue[$];
	sbt_pkg::out_t run_toks[$];
	int mismatches = 0;
	bit idle_off = 1'b0;
	bit hold_sink = 1'b0;
	bit hold_src = 1'b0;
	int src_gap = 0;
	int sink_gap = 0;

	function automatic logic [19:0] sat_sub(logic [19:0] a, logic [19:0] b);
		return (a > b) ? a - b : 20'd0;
	endfunction

	function automatic bit alpha_c(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit digit_c(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	task automatic push_tok(logic [5:0] k, logic [1:0] e, logic [19:0] s, logic [19:0] l);
		sbt_pkg::out_t r;
		r.token_kind = k;
		r.error_code = e;
		r.lexeme_start = s;
		r.lexeme_length = l;
		r.line_number = cur_line;
		r.last_of_run = 1'b0;
		run_toks = {run_toks, r};
	endtask

	task automatic bump_line();
		if (cur_line != 16'hFFFF) cur_line++;
	endtask

	task automatic clear_scanner();
		scan_st = sbt_pkg::M_IDLE;
		cur_pos = '0;
		tok_begin = '0;
		cur_line = first_line;
		word_len = 0;
		foreach (word_buf[i]) word_buf[i] = 8'h00;
	endtask

	function automatic logic [5:0] classify_word();
		string kws [9] = '{"main", "sia", "stampa", "se", "altrimenti", "fun", "and",
			"or", "not"};
		bit hit;
		for (int k = 0; k < 9; k++) begin
			hit = (word_len == kws[k].len());
			for (int j = 0; j < kws[k].len() && hit; j++)
				if (word_buf[j] != kws[k][j]) hit = 0;
			if (hit) return sbt_pkg::K_KW_BASE + 6'(k);
		end
		return sbt_pkg::K_IDENT;
	endfunction

	task automatic close_token(logic [19:0] p);
		case (scan_st)
			sbt_pkg::M_IDENT: push_tok(classify_word(), sbt_pkg::E_NONE, tok_begin,
				sat_sub(p, tok_begin));
			sbt_pkg::M_NUM, sbt_pkg::M_NUM_FRAC: push_tok(sbt_pkg::K_NUMBER, sbt_pkg::E_NONE,
				tok_begin, sat_sub(p, tok_begin));
			sbt_pkg::M_NUM_DOT: begin
				push_tok(sbt_pkg::K_NUMBER, sbt_pkg::E_NONE, tok_begin,
					sat_sub(sat_sub(p, 20'd1), tok_begin));
				push_tok(sbt_pkg::K_ERROR, sbt_pkg::E_UNEXPECTED, sat_sub(p, 20'd1), 20'd1);
			end
			sbt_pkg::M_SLASH: push_tok(sbt_pkg::K_SLASH, sbt_pkg::E_NONE, tok_begin, 20'd1);
			sbt_pkg::M_BANG: push_tok(sbt_pkg::K_ERROR, sbt_pkg::E_UNEXPECTED, tok_begin, 20'd1);
			sbt_pkg::M_EQ: push_tok(sbt_pkg::K_ASSIGN, sbt_pkg::E_NONE, tok_begin, 20'd1);
			sbt_pkg::M_LT: push_tok(sbt_pkg::K_LT, sbt_pkg::E_NONE, tok_begin, 20'd1);
			sbt_pkg::M_GT: push_tok(sbt_pkg::K_GT, sbt_pkg::E_NONE, tok_begin, 20'd1);
			default: ;
		endcase
		scan_st = sbt_pkg::M_IDLE;
	endtask

	task automatic open_token(logic [7:0] c, logic [19:0] p);
		tok_begin = p;
		if (alpha_c(c) || c == "_") begin
			scan_st = sbt_pkg::M_IDENT;
			foreach (word_buf[i]) word_buf[i] = 8'h00;
			word_buf[0] = c;
			word_len = 1;
		end else if (digit_c(c)) begin
			scan_st = sbt_pkg::M_NUM;
		end else begin
			case (c)
				8'h20, 8'h09, 8'h0d, 8'h0b, 8'h0c: ;
				8'h0a: bump_line();
				"\"": begin
					scan_st = sbt_pkg::M_STR;
					tok_begin = (p < POS_LIMIT) ? p + 20'd1 : 20'(POS_LIMIT);
				end
				"(": push_tok(sbt_pkg::K_LPAREN, sbt_pkg::E_NONE, p, 20'd1);
				")": push_tok(sbt_pkg::K_RPAREN, sbt_pkg::E_NONE, p, 20'd1);
				"{": push_tok(sbt_pkg::K_LBRACE, sbt_pkg::E_NONE, p, 20'd1);
				"}": push_tok(sbt_pkg::K_RBRACE, sbt_pkg::E_NONE, p, 20'd1);
				"+": push_tok(sbt_pkg::K_PLUS, sbt_pkg::E_NONE, p, 20'd1);
				"-": push_tok(sbt_pkg::K_MINUS, sbt_pkg::E_NONE, p, 20'd1);
				"*": push_tok(sbt_pkg::K_STAR, sbt_pkg::E_NONE, p, 20'd1);
				";": push_tok(sbt_pkg::K_SEMI, sbt_pkg::E_NONE, p, 20'd1);
				",": push_tok(sbt_pkg::K_COMMA, sbt_pkg::E_NONE, p, 20'd1);
				"/": scan_st = sbt_pkg::M_SLASH;
				"!": scan_st = sbt_pkg::M_BANG;
				"=": scan_st = sbt_pkg::M_EQ;
				"<": scan_st = sbt_pkg::M_LT;
				">": scan_st = sbt_pkg::M_GT;
				default: push_tok(sbt_pkg::K_ERROR, sbt_pkg::E_UNEXPECTED, p, 20'd1);
			endcase
		end
	endtask

	task automatic scan_byte(logic [7:0] c);
		logic [19:0] p;
		bit taken;
		p = cur_pos;
		taken = 1;
		case (scan_st)
			sbt_pkg::M_IDENT:
				if (alpha_c(c) || digit_c(c)) begin
					if (word_len < 10) word_buf[word_len] = c;
					if (word_len <= 10) word_len++;
				end else taken = 0;
			sbt_pkg::M_NUM:
				if (c == ".") scan_st = sbt_pkg::M_NUM_DOT;
				else if (!digit_c(c)) taken = 0;
			sbt_pkg::M_NUM_DOT:
				if (digit_c(c)) scan_st = sbt_pkg::M_NUM_FRAC; else taken = 0;
			sbt_pkg::M_NUM_FRAC:
				if (!digit_c(c)) taken = 0;
			sbt_pkg::M_STR:
				if (c == "\"") begin
					push_tok(sbt_pkg::K_STRING, sbt_pkg::E_NONE, tok_begin,
						sat_sub(p, tok_begin));
					scan_st = sbt_pkg::M_IDLE;
				end else if (c == 8'h0a) bump_line();
			sbt_pkg::M_SLASH:
				if (c == "/") scan_st = sbt_pkg::M_LINEC;
				else if (c == "*") scan_st = sbt_pkg::M_BLOCKC;
				else taken = 0;
			sbt_pkg::M_LINEC:
				if (c == 8'h0a) begin
					bump_line();
					scan_st = sbt_pkg::M_IDLE;
				end
			sbt_pkg::M_BLOCKC:
				if (c == "*") scan_st = sbt_pkg::M_BLOCKSTAR;
				else if (c == 8'h0a) bump_line();
			sbt_pkg::M_BLOCKSTAR:
				if (c == "/") scan_st = sbt_pkg::M_IDLE;
				else if (c != "*") begin
					if (c == 8'h0a) bump_line();
					scan_st = sbt_pkg::M_BLOCKC;
				end
			sbt_pkg::M_BANG:
				if (c == "!") begin
					push_tok(sbt_pkg::K_BANGBANG, sbt_pkg::E_NONE, tok_begin, 20'd2);
					scan_st = sbt_pkg::M_IDLE;
				end else if (c == "=") begin
					push_tok(sbt_pkg::K_NE, sbt_pkg::E_NONE, tok_begin, 20'd2);
					scan_st = sbt_pkg::M_IDLE;
				end else taken = 0;
			sbt_pkg::M_EQ, sbt_pkg::M_LT, sbt_pkg::M_GT:
				if (c == "=") begin
					push_tok(scan_st == sbt_pkg::M_EQ ? sbt_pkg::K_EQ :
						scan_st == sbt_pkg::M_LT ? sbt_pkg::K_LE : sbt_pkg::K_GE,
						sbt_pkg::E_NONE, tok_begin, 20'd2);
					scan_st = sbt_pkg::M_IDLE;
				end else taken = 0;
			default: begin
				scan_st = sbt_pkg::M_IDLE;
				taken = 0;
			end
		endcase
		if (!taken) begin
			close_token(p);
			open_token(c, p);
		end
		cur_pos = (p < POS_LIMIT) ? p + 20'd1 : 20'(POS_LIMIT);
	endtask

	// tokens caused by one accepted beat go to token_queue
	task automatic tokenize_beat(sbt_pkg::in_t b);
		run_toks.delete();
		if (b.has_byte) scan_byte(b.byte_value);
		if (b.is_last) begin
			if (scan_st == sbt_pkg::M_STR)
				push_tok(sbt_pkg::K_UNKNOWN, sbt_pkg::E_UNTERM, sat_sub(tok_begin, 20'd1),
					sat_sub(cur_pos, sat_sub(tok_begin, 20'd1)));
			else
				close_token(cur_pos);
			push_tok(sbt_pkg::K_END, sbt_pkg::E_NONE, cur_pos, 20'd0);
			clear_scanner();
		end
		if (run_toks.size() > 0) run_toks[run_toks.size() - 1].last_of_run = 1'b1;
		foreach (run_toks[i]) token_queue = {token_queue, run_toks[i]};
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) tokenize_beat(in_data);
			if (!in_valid || in_ready) begin
				if (src_gap > 0) begin
					src_gap--;
					in_valid <= 1'b0;
				end else if (!hold_src && pending_beats.size() > 0) begin
					if (!idle_off && $urandom_range(0, 9) == 0) begin
						src_gap = $urandom_range(1, 8) - 1;
						in_valid <= 1'b0;
					end else begin
						in_data <= pending_beats.pop_front();
						in_valid <= 1'b1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and sink
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (token_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected token %p", out_data);
				end else begin
					sbt_pkg::out_t want;
					want = token_queue.pop_front();
					if (want !== out_data) begin
						mismatches++;
						if (mismatches <= 10)
							$display("token mismatch: expected %p got %p", want, out_data);
					end
				end
			end
			if (hold_sink) out_ready <= 1'b0;
			else if (sink_gap > 0) begin
				sink_gap--;
				out_ready <= 1'b0;
			end else if (!idle_off && $urandom_range(0, 7) == 0) begin
				sink_gap = $urandom_range(1, 8) - 1;
				out_ready <= 1'b0;
			end else out_ready <= 1'b1;
		end
	end

	task automatic add_beat(logic [7:0] c, bit hb, bit last);
		sbt_pkg::in_t b;
		b.byte_value = c;
		b.has_byte = hb;
		b.is_last = last;
		pending_beats = {pending_beats, b};
	endtask

	task automatic add_text(string s, bit close_it);
		for (int i = 0; i < s.len(); i++)
			add_beat(s[i], 1'b1, close_it && i == s.len() - 1);
	endtask

	task automatic drain();
		while (pending_beats.size() > 0 || in_valid) @(posedge clk);
		while (token_queue.size() > 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_start_line(logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		first_line = v;
		if (cur_pos == 0 && scan_st == sbt_pkg::M_IDLE) cur_line = v;
	endtask

	function automatic logic [7:0] pick_char();
		string pool = "abcsemainfuotrl_xZ0123456789.(){}+-*/;,!=<>\"\n \t";
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) return 8'($urandom_range(128, 255));
		if (r < 6) return 8'($urandom_range(0, 127));
		return pool[$urandom_range(0, pool.len() - 1)];
	endfunction

	task automatic random_source(int n);
		string words [12] = '{"main", "sia", "stampa", "se", "altrimenti", "fun",
			"and", "or", "not", "altrimentix", "x1", "_q"};
		int k;
		k = 0;
		while (k < n) begin
			if ($urandom_range(0, 2) == 0) begin
				add_text(words[$urandom_range(0, 11)], 0);
				k += 3;
			end else begin
				add_beat(pick_char(), 1'b1, 1'b0);
				k++;
			end
			if ($urandom_range(0, 6) == 0) begin
				add_beat(8'($urandom), 1'b0, 1'b0);
				k++;
			end
		end
		add_beat(pick_char(), 1'($urandom_range(0, 1)), 1'b1);
	endtask

	initial begin
		first_line = sbt_pkg::START_LINE_RST;
		clear_scanner();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// keywords, operators, comments, numbers and strings
		add_text("main sia stampa se altrimenti fun and or not altrimenti1 ", 0);
		add_text("(){}+-*;,!!!=== =<=<>=>/x//c\n/*a**\n*/1.5 2. 7.x\"s\n\"", 0);
		add_beat(8'h00, 1'b1, 1'b0);
		add_beat(8'hFF, 1'b1, 1'b0);
		add_beat(8'h0b, 1'b1, 1'b0);
		add_beat(8'h55, 1'b0, 1'b0);
		add_text("! \"open", 1);
		add_beat(8'h00, 1'b0, 1'b1);
		drain();
		write_start_line(16'hFFFF);
		add_text("a\n=\n", 1);
		add_text("12.", 1);
		drain();
		write_start_line(16'h0000);
		add_text("<", 1);

		// sink stalls long while the source keeps offering
		hold_sink = 1'b1;
		random_source(30);
		repeat (200) @(posedge clk);
		hold_sink = 1'b0;
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_start_line(16'($urandom));
			random_source(32);
			// in phase 2 the source pauses until all tokens are out
			hold_src = (ph == 2);
			if (hold_src) begin
				while (token_queue.size() > 0 || in_valid) @(posedge clk);
				hold_src = 1'b0;
			end
			drain();
		end
		write_start_line(16'd1);
		idle_off = 1'b1;
		random_source(40);
		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && token_queue.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

>>> filelist.f
rtl/sbt_pkg.sv
rtl/source_byte_tokenizer.sv
verif/tb_top.sv
